// ===== sv/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define SCM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define SCM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/scm_pkg.sv =====
package scm_pkg;

  localparam int unsigned SLOTS       = 64;
  localparam int unsigned SLOT_W      = 6;
  localparam int unsigned CNT_W       = 7;
  localparam int unsigned SEC_W       = 16;
  localparam int unsigned WALK_W      = 7;
  localparam int unsigned WRITE_LIMIT = 32;
  localparam logic [SEC_W-1:0] DISK_RESET = 16'd1024;

  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_FLUSH = 2'd2;
  localparam logic [1:0] CMD_NONE  = 2'd3;

  localparam logic [2:0] ACT_HIT         = 3'd0;
  localparam logic [2:0] ACT_FETCH       = 3'd1;
  localparam logic [2:0] ACT_PREFETCH    = 3'd2;
  localparam logic [2:0] ACT_WRITEBACK   = 3'd3;
  localparam logic [2:0] ACT_INSTALL     = 3'd4;
  localparam logic [2:0] ACT_INSTALL_PRE = 3'd5;
  localparam logic [2:0] ACT_IDLE_FLUSH  = 3'd6;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [SEC_W-1:0] sector;
  } req_t;

  typedef struct packed {
    logic [2:0]        action;
    logic [SEC_W-1:0]  sector_res;
    logic [SLOT_W-1:0] slot;
    logic              last;
  } res_t;

  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] waddr;
    logic [SEC_W-1:0]  wdata;
    logic [SLOT_W-1:0] raddr;
  } tag_port_t;

  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] waddr;
    logic [SLOT_W-1:0] wdata;
    logic [SLOT_W-1:0] raddr;
  } que_port_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             busy;
  } stat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_PREF,
    ST_RECL,
    ST_WALK,
    ST_WALKEND,
    ST_POPQ,
    ST_POPT,
    ST_POPE,
    ST_INST,
    ST_EMIT
  } st_e;

  function automatic res_t mk_res(logic [2:0] act, logic [SEC_W-1:0] sec,
                                  logic [SLOT_W-1:0] slot, logic last);
    res_t r;
    r.action     = act;
    r.sector_res = sec;
    r.slot       = slot;
    r.last       = last;
    return r;
  endfunction

endpackage

// ===== sv/scm_ram.sv =====
module scm_ram #(
  parameter int unsigned WIDTH = scm_pkg::SEC_W,
  parameter int unsigned DEPTH = scm_pkg::SLOTS,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/scm_ctrl.sv =====
module scm_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [scm_pkg::SEC_W-1:0] disk_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  scm_pkg::req_t             req_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output scm_pkg::res_t             res_o,
  output scm_pkg::tag_port_t        tag_o,
  input  logic [scm_pkg::SEC_W-1:0] tag_rdata_i,
  output scm_pkg::que_port_t        que_o,
  input  logic [scm_pkg::SLOT_W-1:0] que_rdata_i,
  output scm_pkg::stat_t            stat_o
);

  scm_pkg::st_e state_q, state_d, ret_q, ret_d;
  logic [scm_pkg::SLOTS-1:0] valid_q, valid_d, used_q, used_d, dirty_q, dirty_d;
  logic [scm_pkg::SLOT_W-1:0] hand_q, hand_d, head_q, head_d;
  logic [scm_pkg::CNT_W-1:0] count_q, count_d, scan_q, scan_d;
  logic [scm_pkg::WALK_W-1:0] walk_q, walk_d;
  logic pend_q, pend_d, nc_q, nc_d, pre_q, pre_d, second_q, second_d;
  logic flush_q, flush_d;
  logic [scm_pkg::SLOT_W-1:0] pidx_q, pidx_d, slot_q, slot_d;
  logic [1:0] cmd_q, cmd_d;
  logic [scm_pkg::SEC_W-1:0] sec_q, sec_d;
  scm_pkg::res_t out_q, out_d;
  logic [scm_pkg::SEC_W:0] sec_p1;
  logic [scm_pkg::SEC_W-1:0] inst_sec;

  assign sec_p1   = {1'b0, sec_q} + {{scm_pkg::SEC_W{1'b0}}, 1'b1};
  assign inst_sec = second_q ? sec_p1[scm_pkg::SEC_W-1:0] : sec_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= scm_pkg::ST_IDLE;
      ret_q    <= scm_pkg::ST_IDLE;
      valid_q  <= '0;
      used_q   <= '0;
      dirty_q  <= '0;
      hand_q   <= '0;
      head_q   <= '0;
      count_q  <= '0;
      scan_q   <= '0;
      walk_q   <= '0;
      pend_q   <= 1'b0;
      nc_q     <= 1'b0;
      pre_q    <= 1'b0;
      second_q <= 1'b0;
      flush_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      ret_q    <= ret_d;
      valid_q  <= valid_d;
      used_q   <= used_d;
      dirty_q  <= dirty_d;
      hand_q   <= hand_d;
      head_q   <= head_d;
      count_q  <= count_d;
      scan_q   <= scan_d;
      walk_q   <= walk_d;
      pend_q   <= pend_d;
      nc_q     <= nc_d;
      pre_q    <= pre_d;
      second_q <= second_d;
      flush_q  <= flush_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pidx_q <= pidx_d;
    slot_q <= slot_d;
    cmd_q  <= cmd_d;
    sec_q  <= sec_d;
    out_q  <= out_d;
  end

  always_comb begin
    state_d  = state_q;
    ret_d    = ret_q;
    valid_d  = valid_q;
    used_d   = used_q;
    dirty_d  = dirty_q;
    hand_d   = hand_q;
    head_d   = head_q;
    count_d  = count_q;
    scan_d   = scan_q;
    walk_d   = walk_q;
    pend_d   = pend_q;
    nc_d     = nc_q;
    pre_d    = pre_q;
    second_d = second_q;
    flush_d  = flush_q;
    pidx_d   = pidx_q;
    slot_d   = slot_q;
    cmd_d    = cmd_q;
    sec_d    = sec_q;
    out_d    = out_q;
    tag_o    = '0;
    que_o    = '0;
    case (state_q)
      scm_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_d    = req_i.cmd;
          sec_d    = req_i.sector;
          scan_d   = '0;
          pend_d   = 1'b0;
          nc_d     = 1'b0;
          second_d = 1'b0;
          flush_d  = 1'b0;
          case (req_i.cmd)
            scm_pkg::CMD_NONE: state_d = scm_pkg::ST_IDLE;
            scm_pkg::CMD_FLUSH: begin
              if (count_q == '0) begin
                out_d   = scm_pkg::mk_res(scm_pkg::ACT_IDLE_FLUSH, '0, '0, 1'b1);
                ret_d   = scm_pkg::ST_IDLE;
                state_d = scm_pkg::ST_EMIT;
              end else begin
                flush_d = 1'b1;
                state_d = scm_pkg::ST_POPQ;
              end
            end
            default: state_d = scm_pkg::ST_LOOKUP;
          endcase
        end
      end
      scm_pkg::ST_LOOKUP: begin
        tag_o.raddr = scan_q[scm_pkg::SLOT_W-1:0];
        pend_d = (scan_q != scm_pkg::CNT_W'(scm_pkg::SLOTS));
        pidx_d = scan_q[scm_pkg::SLOT_W-1:0];
        if (pend_d) begin
          scan_d = scan_q + 1'b1;
        end
        if (pend_q && valid_q[pidx_q] && tag_rdata_i == sec_q) begin
          if (cmd_q == scm_pkg::CMD_WRITE && !dirty_q[pidx_q]) begin
            dirty_d[pidx_q] = 1'b1;
            if (count_q < scm_pkg::CNT_W'(scm_pkg::SLOTS)) begin
              que_o.we    = 1'b1;
              que_o.waddr = head_q + count_q[scm_pkg::SLOT_W-1:0];
              que_o.wdata = pidx_q;
              count_d     = count_q + 1'b1;
            end
          end
          used_d[pidx_q] = 1'b1;
          out_d   = scm_pkg::mk_res(scm_pkg::ACT_HIT, sec_q, pidx_q, 1'b1);
          ret_d   = scm_pkg::ST_IDLE;
          state_d = scm_pkg::ST_EMIT;
        end else begin
          if (pend_q && valid_q[pidx_q] && {1'b0, tag_rdata_i} == sec_p1) begin
            nc_d = 1'b1;
          end
          if (!pend_q && scan_q == scm_pkg::CNT_W'(scm_pkg::SLOTS)) begin
            if (cmd_q == scm_pkg::CMD_WRITE) begin
              state_d = scm_pkg::ST_RECL;
            end else begin
              pre_d   = (sec_p1 < {1'b0, disk_i}) && !nc_q;
              out_d   = scm_pkg::mk_res(scm_pkg::ACT_FETCH, sec_q, '0, 1'b0);
              ret_d   = pre_d ? scm_pkg::ST_PREF : scm_pkg::ST_RECL;
              state_d = scm_pkg::ST_EMIT;
            end
          end
        end
      end
      scm_pkg::ST_PREF: begin
        out_d = scm_pkg::mk_res(scm_pkg::ACT_PREFETCH, sec_p1[scm_pkg::SEC_W-1:0], '0, 1'b0);
        ret_d   = scm_pkg::ST_RECL;
        state_d = scm_pkg::ST_EMIT;
      end
      scm_pkg::ST_RECL: begin
        walk_d = '0;
        if (count_q > scm_pkg::CNT_W'(scm_pkg::WRITE_LIMIT)) begin
          state_d = scm_pkg::ST_POPQ;
        end else begin
          state_d = scm_pkg::ST_WALK;
        end
      end
      scm_pkg::ST_WALK: begin
        hand_d = hand_q + 1'b1;
        if (!valid_q[hand_q] || (!used_q[hand_q] && !dirty_q[hand_q])) begin
          slot_d  = hand_q;
          state_d = scm_pkg::ST_INST;
        end else begin
          used_d[hand_q] = 1'b0;
          if (walk_q == scm_pkg::WALK_W'(2 * scm_pkg::SLOTS - 1)) begin
            state_d = scm_pkg::ST_WALKEND;
          end else begin
            walk_d = walk_q + 1'b1;
          end
        end
      end
      scm_pkg::ST_WALKEND: begin
        if (count_q != '0) begin
          state_d = scm_pkg::ST_POPQ;
        end else begin
          slot_d  = hand_q;
          hand_d  = hand_q + 1'b1;
          state_d = scm_pkg::ST_INST;
        end
      end
      scm_pkg::ST_POPQ: begin
        que_o.raddr = head_q;
        state_d     = scm_pkg::ST_POPT;
      end
      scm_pkg::ST_POPT: begin
        slot_d      = que_rdata_i;
        tag_o.raddr = que_rdata_i;
        head_d      = head_q + 1'b1;
        count_d     = count_q - 1'b1;
        state_d     = scm_pkg::ST_POPE;
      end
      scm_pkg::ST_POPE: begin
        dirty_d[slot_q] = 1'b0;
        if (flush_q) begin
          valid_d[slot_q] = 1'b0;
          used_d[slot_q]  = 1'b0;
          ret_d = (count_q == '0) ? scm_pkg::ST_IDLE : scm_pkg::ST_POPQ;
        end else begin
          ret_d = scm_pkg::ST_INST;
        end
        out_d = scm_pkg::mk_res(scm_pkg::ACT_WRITEBACK, tag_rdata_i, slot_q,
                                flush_q && count_q == '0);
        state_d = scm_pkg::ST_EMIT;
      end
      scm_pkg::ST_INST: begin
        tag_o.we        = 1'b1;
        tag_o.waddr     = slot_q;
        tag_o.wdata     = inst_sec;
        valid_d[slot_q] = 1'b1;
        used_d[slot_q]  = 1'b1;
        ret_d           = scm_pkg::ST_IDLE;
        state_d         = scm_pkg::ST_EMIT;
        if (cmd_q == scm_pkg::CMD_WRITE) begin
          dirty_d[slot_q] = 1'b1;
          if (count_q < scm_pkg::CNT_W'(scm_pkg::SLOTS)) begin
            que_o.we    = 1'b1;
            que_o.waddr = head_q + count_q[scm_pkg::SLOT_W-1:0];
            que_o.wdata = slot_q;
            count_d     = count_q + 1'b1;
          end
          out_d = scm_pkg::mk_res(scm_pkg::ACT_INSTALL, sec_q, slot_q, 1'b1);
        end else if (second_q) begin
          out_d = scm_pkg::mk_res(scm_pkg::ACT_INSTALL_PRE, inst_sec, slot_q, 1'b1);
        end else begin
          out_d = scm_pkg::mk_res(scm_pkg::ACT_INSTALL, sec_q, slot_q, !pre_q);
          if (pre_q) begin
            second_d = 1'b1;
            ret_d    = scm_pkg::ST_RECL;
          end
        end
      end
      scm_pkg::ST_EMIT: begin
        if (out_ready_i) begin
          state_d = ret_q;
        end
      end
      default: state_d = scm_pkg::ST_IDLE;
    endcase
  end

  assign in_ready_o   = (state_q == scm_pkg::ST_IDLE);
  assign out_valid_o  = (state_q == scm_pkg::ST_EMIT);
  assign res_o        = out_q;
  assign stat_o.count = count_q;
  assign stat_o.busy  = (state_q != scm_pkg::ST_IDLE);

endmodule

// ===== sv/sector_cache_clock_writebehind_top.sv =====
// Channel    Direction  Signals
// request    in         in_valid_i, in_ready_o, req_i
// result     out        out_valid_o, out_ready_i, res_o
// config     in         cfg_we_i, cfg_wdata_i
//
// A request runs alone: the tag scan, each clock walk and each writeback end before the next request is taken.
// Each result waits in the output register until taken.
// Reset clears all slot bits, the hand and the write queue at once; no clearing pass.
// A stalled result holds the sequencer; a new request is taken only when idle.
`include "assert_macros.svh"

module sector_cache_clock_writebehind_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  scm_pkg::req_t             req_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output scm_pkg::res_t             res_o,
  input  logic                      cfg_we_i,
  input  logic [scm_pkg::SEC_W-1:0] cfg_wdata_i
);

  logic [scm_pkg::SEC_W-1:0] disk_q;
  scm_pkg::tag_port_t tag_port;
  scm_pkg::que_port_t que_port;
  logic [scm_pkg::SEC_W-1:0] tag_rdata;
  logic [scm_pkg::SLOT_W-1:0] que_rdata;
  scm_pkg::stat_t stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      disk_q <= scm_pkg::DISK_RESET;
    end else if (cfg_we_i) begin
      disk_q <= cfg_wdata_i;
    end
  end

  scm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .disk_i      (disk_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_i       (req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res_o),
    .tag_o       (tag_port),
    .tag_rdata_i (tag_rdata),
    .que_o       (que_port),
    .que_rdata_i (que_rdata),
    .stat_o      (stat)
  );

  scm_ram #(
    .WIDTH (scm_pkg::SEC_W),
    .DEPTH (scm_pkg::SLOTS)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (tag_port.we),
    .waddr_i (tag_port.waddr),
    .wdata_i (tag_port.wdata),
    .raddr_i (tag_port.raddr),
    .rdata_o (tag_rdata)
  );

  scm_ram #(
    .WIDTH (scm_pkg::SLOT_W),
    .DEPTH (scm_pkg::SLOTS)
  ) u_que_ram (
    .clk_i   (clk_i),
    .we_i    (que_port.we),
    .waddr_i (que_port.waddr),
    .wdata_i (que_port.wdata),
    .raddr_i (que_port.raddr),
    .rdata_o (que_rdata)
  );

  `SCM_ASSERT_NOW(a_excl, out_valid_o, !in_ready_o, "Result shown while idle.")
  `SCM_ASSERT_NOW(a_count, 1'b1, stat.count <= scm_pkg::CNT_W'(scm_pkg::SLOTS), "Queue overflow.")
  `SCM_ASSERT_NEXT(a_busy, in_valid_i && in_ready_o && req_i.cmd != scm_pkg::CMD_NONE, stat.busy, "Request not started.")

endmodule
